>>> design/square_matrix_multiply_core_macros.svh
// assertion macros for the square matrix multiply core checker
`ifndef SQUARE_MATRIX_MULTIPLY_CORE_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/smm_pkg.sv
// shared types and constants of the square matrix multiply core
package smm_pkg;

  localparam int VAL_W       = 32;
  localparam int STATE_W     = 3;
  localparam int ORDER_W     = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;
  localparam logic MAT_LEFT     = 1'b0;
  localparam logic MAT_RIGHT    = 1'b1;

  // tags that travel with one multiply-accumulate step
  typedef struct packed {
    logic               first;
    logic               last_i;
    logic               last_el;
    logic [STATE_W-1:0] f;
    logic [STATE_W-1:0] t;
  } smm_tag_t;

endpackage

>>> design/smm_ram.sv
// single-port-write, single-port-read synchronous memory with registered read data
module smm_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/smm_mac.sv
// multiply, scale, accumulate and saturate datapath with result register
module smm_mac
  import smm_pkg::*;
#(
  parameter int MAX_ORDER = 8,
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               v1,
  input  smm_tag_t           tag1,
  input  logic [VAL_W-1:0]   a_data,
  input  logic [VAL_W-1:0]   b_data,
  output logic               res_valid,
  output logic [STATE_W-1:0] res_from,
  output logic [STATE_W-1:0] res_to,
  output logic [VAL_W-1:0]   res_value,
  output logic               res_sat,
  output logic               res_last,
  output logic               fin
);

  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = PROD_W - FRAC_BITS + $clog2(MAX_ORDER) + 1;

  logic                     v2_r;
  smm_tag_t                 tag2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] shifted;
  logic signed [ACC_W-1:0]  scaled;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                     ovf;
  logic [VAL_W-1:0]         clip;

  logic               out_valid_r;
  logic [STATE_W-1:0] out_from_r;
  logic [STATE_W-1:0] out_to_r;
  logic [VAL_W-1:0]   out_value_r;
  logic               out_sat_r;
  logic               out_last_r;

  assign prod_nxt = PROD_W'($signed(a_data)) * PROD_W'($signed(b_data));

  // arithmetic shift rounds toward minus infinity
  assign shifted = prod_r >>> FRAC_BITS;
  assign scaled  = ACC_W'(shifted);
  assign acc_nxt = (tag2_r.first ? ACC_W'(0) : acc_r) + scaled;

  // out of range when the bits above the 32-bit sign are not all copies of it
  assign ovf  = !((&acc_nxt[ACC_W-1:VAL_W-1]) || !(|acc_nxt[ACC_W-1:VAL_W-1]));
  assign clip = acc_nxt[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag2_r <= tag1;
      prod_r <= prod_nxt;
      if (v2_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v2_r && tag2_r.last_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2_r && tag2_r.last_i) begin
      out_from_r  <= tag2_r.f;
      out_to_r    <= tag2_r.t;
      out_value_r <= ovf ? clip : acc_nxt[VAL_W-1:0];
      out_sat_r   <= ovf;
      out_last_r  <= tag2_r.last_el;
    end
  end

  assign fin       = adv && v2_r && tag2_r.last_el;
  assign res_valid = out_valid_r;
  assign res_from  = out_from_r;
  assign res_to    = out_to_r;
  assign res_value = out_value_r;
  assign res_sat   = out_sat_r;
  assign res_last  = out_last_r;

endmodule

>>> design/square_matrix_multiply_core.sv
// Square matrix multiplier of configurable order over two element memories. A load request
// writes one element of the left or right matrix, and loads stream at one per cycle while no
// compute is in progress. A compute request makes the block read one left and one right element
// per cycle while the output is not stalled, and run them through a single 32x32 multiplier and
// an accumulator wide enough for the exact sum: it steps through order^3 multiply-accumulate
// operations, limited by the one read port of each memory and the shared multiplier. in_tready
// stays low from the compute request until the final product element enters the output
// register; back pressure on the output freezes the pipeline.
// The memories have no reset; elements must be loaded before they are used.
module square_matrix_multiply_core
  import smm_pkg::*;
#(
  parameter int MAX_ORDER = 8,
  parameter int FRAC_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [ORDER_W-1:0]     cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // from_state, to_state, element_value
  input  logic [1:0]             in_tuser,   // kind, which_matrix
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_from, out_to, product_value
  output logic [0:0]             out_tuser,  // saturated
  output logic                   out_tlast
);

  localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CNT_W  = $clog2(MAX_ORDER + 1);
  localparam logic [ADDR_W-1:0]  ROW   = ADDR_W'(MAX_ORDER);
  localparam logic [ORDER_W-1:0] MAXO  = ORDER_W'(MAX_ORDER);

  logic               in_acc;
  logic               in_kind;
  logic               in_which;
  logic [STATE_W-1:0] in_fs;
  logic [STATE_W-1:0] in_ts;
  logic [VAL_W-1:0]   in_val;
  logic               load_ok;
  logic [ADDR_W-1:0]  wr_addr;

  logic [ORDER_W-1:0] order_r;
  logic [ORDER_W-1:0] act_order;

  logic             busy_r;
  logic             issue_r;
  logic [IDX_W-1:0] cf_r;
  logic [IDX_W-1:0] ct_r;
  logic [IDX_W-1:0] ci_r;
  logic [CNT_W-1:0] n_r;
  logic [IDX_W-1:0] nm1;
  logic             v1_r;
  smm_tag_t         tag;
  smm_tag_t         tag1_r;
  logic             adv;
  logic             rd_en;
  logic [ADDR_W-1:0] l_raddr;
  logic [ADDR_W-1:0] r_raddr;
  logic [VAL_W-1:0]  l_rdata;
  logic [VAL_W-1:0]  r_rdata;

  logic               res_valid;
  logic [STATE_W-1:0] res_from;
  logic [STATE_W-1:0] res_to;
  logic [VAL_W-1:0]   res_value;
  logic               res_sat;
  logic               res_last;
  logic               fin;

  assign in_kind  = in_tuser[0];
  assign in_which = in_tuser[1];
  assign in_fs    = in_tdata[2:0];
  assign in_ts    = in_tdata[5:3];
  assign in_val   = in_tdata[37:6];

  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign load_ok   = in_acc && (in_kind == KIND_LOAD) &&
                     ({1'b0, in_fs} < MAXO) && ({1'b0, in_ts} < MAXO);
  assign wr_addr   = ADDR_W'(ADDR_W'(in_fs[IDX_W-1:0]) * ROW) + ADDR_W'(in_ts[IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RESET;
    end else if (cfg_we) begin
      order_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (order_r == '0) begin
      act_order = ORDER_W'(1);
    end else if (order_r > MAXO) begin
      act_order = MAXO;
    end else begin
      act_order = order_r;
    end
  end

  assign adv = !res_valid || out_tready;
  assign nm1 = IDX_W'(n_r - CNT_W'(1));

  always_comb begin
    tag.first   = (ci_r == '0);
    tag.last_i  = (ci_r == nm1);
    tag.last_el = (ci_r == nm1) && (ct_r == nm1) && (cf_r == nm1);
    tag.f       = STATE_W'(cf_r);
    tag.t       = STATE_W'(ct_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      issue_r <= 1'b0;
      cf_r    <= '0;
      ct_r    <= '0;
      ci_r    <= '0;
      n_r     <= '0;
      v1_r    <= 1'b0;
    end else begin
      if (in_acc && (in_kind == KIND_COMPUTE)) begin
        busy_r  <= 1'b1;
        issue_r <= 1'b1;
        cf_r    <= '0;
        ct_r    <= '0;
        ci_r    <= '0;
        n_r     <= CNT_W'(act_order);
      end else begin
        if (fin) begin
          busy_r <= 1'b0;
        end
        if (adv && issue_r) begin
          if (tag.last_i) begin
            ci_r <= '0;
            if (ct_r == nm1) begin
              ct_r <= '0;
              cf_r <= cf_r + IDX_W'(1);
            end else begin
              ct_r <= ct_r + IDX_W'(1);
            end
          end else begin
            ci_r <= ci_r + IDX_W'(1);
          end
          if (tag.last_el) begin
            issue_r <= 1'b0;
          end
        end
      end
      if (adv) begin
        v1_r <= issue_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && issue_r) begin
      tag1_r <= tag;
    end
  end

  assign rd_en   = adv && issue_r;
  assign l_raddr = ADDR_W'(ADDR_W'(ci_r) * ROW) + ADDR_W'(ct_r);
  assign r_raddr = ADDR_W'(ADDR_W'(cf_r) * ROW) + ADDR_W'(ci_r);

  smm_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (VAL_W)
  ) u_left (
    .clk   (clk),
    .we    (load_ok && (in_which == MAT_LEFT)),
    .waddr (wr_addr),
    .wdata (in_val),
    .re    (rd_en),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  smm_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (VAL_W)
  ) u_right (
    .clk   (clk),
    .we    (load_ok && (in_which == MAT_RIGHT)),
    .waddr (wr_addr),
    .wdata (in_val),
    .re    (rd_en),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  smm_mac #(
    .MAX_ORDER (MAX_ORDER),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .v1        (v1_r),
    .tag1      (tag1_r),
    .a_data    (l_rdata),
    .b_data    (r_rdata),
    .res_valid (res_valid),
    .res_from  (res_from),
    .res_to    (res_to),
    .res_value (res_value),
    .res_sat   (res_sat),
    .res_last  (res_last),
    .fin       (fin)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {2'b00, res_value, res_to, res_from};
  assign out_tuser  = res_sat;
  assign out_tlast  = res_last;

endmodule

>>> design/smm_checker.sv
// port-level checker for the square matrix multiply core, with its bind
`include "square_matrix_multiply_core_macros.svh"

module smm_checker
  import smm_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [1:0]             in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]             out_tuser,
  input logic                   out_tlast
);

  logic                   out_wait;
  logic [OUT_TDATA_W+1:0] out_bus;
  logic                   compute_req;
  logic [VAL_W-1:0]       out_val;
  logic                   at_limit;
  logic                   on_diag;

  assign out_wait    = out_tvalid && !out_tready;
  assign out_bus     = {out_tlast, out_tuser, out_tdata};
  assign compute_req = in_tvalid && in_tready && (in_tuser[0] == KIND_COMPUTE);
  assign out_val     = out_tdata[37:6];
  assign at_limit    = (out_val == 32'h7fffffff) || (out_val == 32'h80000000);
  assign on_diag     = (out_tdata[2:0] == out_tdata[5:3]);

  `SMM_ASSERT_NEXT(a_out_hold, out_wait, out_tvalid && $stable(out_bus), "stalled result changed")
  `SMM_ASSERT_NEXT(a_busy_after_compute, compute_req, !in_tready, "request taken during compute")
  `SMM_ASSERT_NOW(a_sat_value, out_tvalid && out_tuser[0], at_limit, "saturated value off limit")
  `SMM_ASSERT_NOW(a_last_diag, out_tvalid && out_tlast, on_diag, "last result off the diagonal")

endmodule

bind square_matrix_multiply_core smm_checker u_smm_checker (.*);

>>> dv/square_matrix_multiply_core_tb.sv
// testbench for square_matrix_multiply_core: products checked against a local predictor that mirrors the loads
`timescale 1ns / 1ps

module square_matrix_multiply_core_tb
  import smm_pkg::*;
();

  localparam int MAX_ORDER = 8;
  localparam int FRAC_BITS = 24;
  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AT_ELEM = 120;
  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic [STATE_W-1:0] from_s;
    logic [STATE_W-1:0] to_s;
    logic [VAL_W-1:0]   value;
    logic               sat;
    logic               last;
  } product_elem_t;

  class product_scoreboard;
    logic signed [VAL_W-1:0] left_m [MAX_ORDER*MAX_ORDER];
    logic signed [VAL_W-1:0] right_m [MAX_ORDER*MAX_ORDER];
    logic [ORDER_W-1:0] order_reg;
    product_elem_t expected_elems [$];
    int mismatches;

    function new();
      foreach (left_m[k]) begin
        left_m[k] = '0;
        right_m[k] = '0;
      end
      order_reg = ORDER_RESET;
      mismatches = 0;
    endfunction

    function int active_order();
      if (order_reg == 0) return 1;
      if (order_reg > MAX_ORDER) return MAX_ORDER;
      return int'(order_reg);
    endfunction

    function void note_request(logic kind, logic which, logic [STATE_W-1:0] fs,
                               logic [STATE_W-1:0] ts, logic [VAL_W-1:0] val);
      int n;
      logic signed [63:0] acc;
      logic signed [63:0] term;
      product_elem_t e;
      if (kind == KIND_LOAD) begin
        if (which == MAT_LEFT) left_m[fs * MAX_ORDER + ts] = val;
        else right_m[fs * MAX_ORDER + ts] = val;
      end else begin
        n = active_order();
        for (int f = 0; f < n; f++) begin
          for (int t = 0; t < n; t++) begin
            acc = '0;
            for (int i = 0; i < n; i++) begin
              term = left_m[i * MAX_ORDER + t] * right_m[f * MAX_ORDER + i];
              acc = acc + (term >>> FRAC_BITS);
            end
            e.from_s = STATE_W'(f);
            e.to_s = STATE_W'(t);
            if (acc > SAT_HI) begin
              e.value = VAL_W'(SAT_HI);
              e.sat = 1'b1;
            end else if (acc < SAT_LO) begin
              e.value = VAL_W'(SAT_LO);
              e.sat = 1'b1;
            end else begin
              e.value = VAL_W'(acc);
              e.sat = 1'b0;
            end
            e.last = (f == n - 1) && (t == n - 1);
            expected_elems.insert(expected_elems.size(), e);
          end
        end
      end
    endfunction

    function void report(string field, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
      mismatches++;
    endfunction

    function void check_element(logic [STATE_W-1:0] f, logic [STATE_W-1:0] t,
                                logic [VAL_W-1:0] v, logic s, logic l);
      product_elem_t e;
      if (expected_elems.size() == 0) begin
        $display("%0t: unexpected product element, expected none actual %0d,%0d %h",
                 $time, f, t, v);
        mismatches++;
      end else begin
        e = expected_elems.pop_front();
        if (f !== e.from_s) report("out_from", VAL_W'(e.from_s), VAL_W'(f));
        if (t !== e.to_s) report("out_to", VAL_W'(e.to_s), VAL_W'(t));
        if (v !== e.value) report("product_value", e.value, v);
        if (s !== e.sat) report("saturated", VAL_W'(e.sat), VAL_W'(s));
        if (l !== e.last) report("last", VAL_W'(e.last), VAL_W'(l));
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [ORDER_W-1:0]     cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // from_state, to_state, element_value
  logic [1:0]             in_tuser;   // kind, which_matrix
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // out_from, out_to, product_value
  logic [0:0]             out_tuser;  // saturated
  logic                   out_tlast;

  product_scoreboard sb;
  bit loaded [2][MAX_ORDER*MAX_ORDER];
  int sent_count;
  bit in_burst;
  logic [ORDER_W-1:0] phase_orders [12] = '{4'd2, 4'd3, 4'd0, 4'd5, 4'd4, 4'd6,
                                            4'd7, 4'd15, 4'd9, 4'd3, 4'd1, 4'd8};

  square_matrix_multiply_core #(
    .MAX_ORDER(MAX_ORDER),
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic [VAL_W-1:0] rand_elem();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        3: return 32'h0000_0001;
        default: return 32'h0000_0000;
      endcase
    end else if (sel < 3) begin
      return $urandom();
    end
    // mostly within +-2.0 so that sums stay in range
    return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
  endfunction

  task automatic send_request(input logic kind, input logic which,
                              input logic [STATE_W-1:0] fs, input logic [STATE_W-1:0] ts,
                              input logic [VAL_W-1:0] val);
    int gap;
    if (sent_count % 16 == 0) in_burst = ($urandom_range(0, 3) == 0);
    gap = in_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {which, kind};
    in_tdata <= {2'b00, val, ts, fs};
    do @(posedge clk); while (!in_tready);
    sb.note_request(kind, which, fs, ts, val);
    if (kind == KIND_LOAD) loaded[which][fs * MAX_ORDER + ts] = 1'b1;
    sent_count++;
  endtask

  task automatic send_compute();
    send_request(KIND_COMPUTE, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                 3'($urandom_range(0, 7)), $urandom());
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_elems.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_order(input logic [ORDER_W-1:0] ord);
    cfg_we <= 1'b1;
    cfg_wdata <= ord;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.order_reg = ord;
  endtask

  task automatic run_directed();
    write_order(4'd1);
    // most negative squared saturates high
    send_request(KIND_LOAD, MAT_LEFT, 3'd0, 3'd0, 32'h8000_0000);
    send_request(KIND_LOAD, MAT_RIGHT, 3'd0, 3'd0, 32'h8000_0000);
    send_compute();
    // max times min saturates low
    send_request(KIND_LOAD, MAT_LEFT, 3'd0, 3'd0, 32'h7fff_ffff);
    send_compute();
    // tiny negative product rounds toward minus infinity
    send_request(KIND_LOAD, MAT_LEFT, 3'd0, 3'd0, 32'hffff_ffff);
    send_request(KIND_LOAD, MAT_RIGHT, 3'd0, 3'd0, 32'h0000_0001);
    send_compute();
    send_request(KIND_LOAD, MAT_RIGHT, 3'd0, 3'd0, 32'h7fff_ffff);
    send_request(KIND_LOAD, MAT_LEFT, 3'd0, 3'd0, 32'h7fff_ffff);
    send_compute();
    // store beyond the active order, never read at order one
    send_request(KIND_LOAD, MAT_LEFT, 3'd7, 3'd7, 32'h1234_5678);
    send_request(KIND_LOAD, MAT_RIGHT, 3'd7, 3'd7, 32'hedcb_a987);
    send_request(KIND_LOAD, MAT_LEFT, 3'd0, 3'd0, 32'h0100_0000);
    send_request(KIND_LOAD, MAT_RIGHT, 3'd0, 3'd0, 32'h0080_0000);
    send_compute();
    send_request(KIND_LOAD, MAT_LEFT, 3'd0, 3'd0, 32'h0000_0000);
    send_compute();
    drain();
  endtask

  task automatic run_phase(input logic [ORDER_W-1:0] ord, input int n_items);
    int n;
    int k;
    int start;
    int idx;
    int pick;
    bit have_missing;
    bit computed;
    logic mwhich;
    logic [STATE_W-1:0] mfs;
    logic [STATE_W-1:0] mts;
    write_order(ord);
    n = sb.active_order();
    k = 0;
    computed = 1'b0;
    while (k < n_items || !computed) begin
      // look for an element the next product would read but nobody wrote
      have_missing = 1'b0;
      start = $urandom_range(0, 127);
      for (int j = 0; j < 128 && !have_missing; j++) begin
        idx = (start + j) % 128;
        if (!loaded[idx / 64][idx % 64] && (idx % 64) / MAX_ORDER < n &&
            idx % MAX_ORDER < n) begin
          have_missing = 1'b1;
          mwhich = 1'(idx / 64);
          mfs = STATE_W'((idx % 64) / MAX_ORDER);
          mts = STATE_W'(idx % MAX_ORDER);
        end
      end
      pick = $urandom_range(0, 99);
      if (!have_missing && (pick < 15 || k >= n_items)) begin
        send_compute();
        computed = 1'b1;
      end else if (have_missing) begin
        send_request(KIND_LOAD, mwhich, mfs, mts, rand_elem());
      end else begin
        send_request(KIND_LOAD, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                     3'($urandom_range(0, 7)), rand_elem());
      end
      k++;
    end
    // keep a request waiting behind the last product
    send_request(KIND_LOAD, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                 3'($urandom_range(0, 7)), rand_elem());
    drain();
  endtask

  initial begin
    sb = new();
    sent_count = 0;
    in_burst = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    foreach (phase_orders[p]) run_phase(phase_orders[p], 2);
    if (sb.mismatches == 0) begin
      $display("square_matrix_multiply_core_tb OK");
    end else begin
      $display("square_matrix_multiply_core_tb NOT OK");
    end
    $finish;
  end

  // result side with random stalls and one long hold in the middle of a product run
  initial begin
    int gap;
    int seen;
    bit out_burst;
    bit held;
    bit prev_last;
    seen = 0;
    out_burst = 1'b0;
    held = 1'b0;
    prev_last = 1'b1;
    out_tready <= 1'b0;
    repeat (6) @(posedge clk);
    forever begin
      if (seen % 24 == 0) out_burst = ($urandom_range(0, 3) == 0);
      if (!held && seen >= HOLD_AT_ELEM && !prev_last) begin
        held = 1'b1;
        gap = LONG_HOLD;
      end else begin
        gap = out_burst ? 0 : $urandom_range(0, 9);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_element(out_tdata[2:0], out_tdata[5:3], out_tdata[37:6], out_tuser[0],
                       out_tlast);
      prev_last = out_tlast;
      seen++;
    end
  end

  initial begin
    #20_000_000;
    $display("square_matrix_multiply_core_tb NOT OK");
    $finish;
  end

endmodule
